// ----- rtl/core/rgbpk_pkg.sv -----
`timescale 1ns / 1ps

package rgbpk_pkg;

	// Bytes the pixel word may span, and the output slots carried per beat.
	localparam int MAX_BYTES  = 4;
	localparam int OUT_SLOTS  = 4;
	localparam int BYTE_LIMIT = (MAX_BYTES < OUT_SLOTS) ? MAX_BYTES : OUT_SLOTS;
	localparam int SEL_W      = $clog2(OUT_SLOTS);

	localparam int LEVEL_W    = 8;
	localparam int MASK_W     = 32;
	localparam int POS_W      = 5;
	localparam int LEN_W      = 5;
	localparam int WIDE_W     = 16;
	localparam int COUNT_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int WORD_W     = 8 * OUT_SLOTS;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RED_MASK        = 3'd0,
		CFG_GREEN_MASK      = 3'd1,
		CFG_BLUE_MASK       = 3'd2,
		CFG_BYTES_PER_PIXEL = 3'd3,
		CFG_MSB_FIRST       = 3'd4
	} cfg_reg_t;

	// Decoded channel field: lowest bit and run length (0..16).
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] len;
	} chan_fmt_t;

	typedef struct packed {
		chan_fmt_t            red;
		chan_fmt_t            green;
		chan_fmt_t            blue;
		logic [COUNT_W-1:0]   count;
		logic                 msb_first;
	} pix_cfg_t;

	// Map a raw bytes-per-pixel value onto the range the packer supports.
	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] raw);
		logic [COUNT_W-1:0] res;
		res = raw;
		if (raw == '0) begin
			res = COUNT_W'(1);
		end else if (raw > COUNT_W'(BYTE_LIMIT)) begin
			res = COUNT_W'(BYTE_LIMIT);
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/rgbpk_mask_decode.sv -----
`timescale 1ns / 1ps

module rgbpk_mask_decode (
	input  logic [rgbpk_pkg::MASK_W-1:0] mask,
	output rgbpk_pkg::chan_fmt_t         fmt
);

	logic [rgbpk_pkg::MASK_W-1:0] shifted;
	logic [rgbpk_pkg::POS_W-1:0]  pos;
	logic [rgbpk_pkg::LEN_W-1:0]  len;

	// Lowest set bit of the mask.
	always_comb begin
		pos = '0;
		for (int i = rgbpk_pkg::MASK_W - 1; i >= 0; i--) begin
			if (mask[i]) begin
				pos = rgbpk_pkg::POS_W'(i);
			end
		end
	end

	assign shifted = mask >> pos;

	// Length of the run of ones at the bottom, capped at 16. An all-zero mask
	// lands on zero here, so that channel adds nothing.
	always_comb begin
		len = rgbpk_pkg::LEN_W'(rgbpk_pkg::WIDE_W);
		for (int i = rgbpk_pkg::WIDE_W - 1; i >= 0; i--) begin
			if (!shifted[i]) begin
				len = rgbpk_pkg::LEN_W'(i);
			end
		end
	end

	assign fmt.pos = pos;
	assign fmt.len = len;

endmodule

// ----- rtl/core/rgbpk_cfg_regs.sv -----
`timescale 1ns / 1ps

module rgbpk_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rgbpk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgbpk_pkg::MASK_W-1:0]    cfg_wdata,
	output rgbpk_pkg::pix_cfg_t             cfg
);

	rgbpk_pkg::chan_fmt_t wr_fmt;
	rgbpk_pkg::pix_cfg_t  cfg_q;

	// One decoder on the write path; the decoded form is what gets stored.
	rgbpk_mask_decode u_decode (
		.mask (cfg_wdata),
		.fmt  (wr_fmt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red.pos   <= rgbpk_pkg::POS_W'(16);
			cfg_q.red.len   <= rgbpk_pkg::LEN_W'(8);
			cfg_q.green.pos <= rgbpk_pkg::POS_W'(8);
			cfg_q.green.len <= rgbpk_pkg::LEN_W'(8);
			cfg_q.blue.pos  <= '0;
			cfg_q.blue.len  <= rgbpk_pkg::LEN_W'(8);
			cfg_q.count     <= rgbpk_pkg::clamp_count(rgbpk_pkg::COUNT_W'(4));
			cfg_q.msb_first <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (rgbpk_pkg::cfg_reg_t'(cfg_index))
				rgbpk_pkg::CFG_RED_MASK:        cfg_q.red   <= wr_fmt;
				rgbpk_pkg::CFG_GREEN_MASK:      cfg_q.green <= wr_fmt;
				rgbpk_pkg::CFG_BLUE_MASK:       cfg_q.blue  <= wr_fmt;
				rgbpk_pkg::CFG_BYTES_PER_PIXEL: begin
					cfg_q.count <= rgbpk_pkg::clamp_count(cfg_wdata[rgbpk_pkg::COUNT_W-1:0]);
				end
				rgbpk_pkg::CFG_MSB_FIRST:       cfg_q.msb_first <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/rgbpk_pixel_pack.sv -----
`timescale 1ns / 1ps

module rgbpk_pixel_pack (
	input  logic [rgbpk_pkg::LEVEL_W-1:0] red_level,
	input  logic [rgbpk_pkg::LEVEL_W-1:0] green_level,
	input  logic [rgbpk_pkg::LEVEL_W-1:0] blue_level,
	input  rgbpk_pkg::pix_cfg_t           cfg,
	output logic [7:0]                    out_bytes [rgbpk_pkg::OUT_SLOTS]
);

	logic [rgbpk_pkg::WORD_W-1:0] word;

	// Replicate the byte to 16 bits, keep the top len bits, move to pos.
	function automatic logic [rgbpk_pkg::WORD_W-1:0] place(
		input logic [rgbpk_pkg::LEVEL_W-1:0] level,
		input rgbpk_pkg::chan_fmt_t          fmt
	);
		logic [rgbpk_pkg::WIDE_W-1:0] wide;
		wide = {level, level} >> (rgbpk_pkg::LEN_W'(rgbpk_pkg::WIDE_W) - fmt.len);
		return rgbpk_pkg::WORD_W'(wide) << fmt.pos;
	endfunction

	assign word = place(red_level, cfg.red) | place(green_level, cfg.green)
		| place(blue_level, cfg.blue);

	// Slot k takes byte k, or byte count-1-k when the high end goes out first.
	always_comb begin
		logic [rgbpk_pkg::COUNT_W-1:0] sel;
		for (int k = 0; k < rgbpk_pkg::OUT_SLOTS; k++) begin
			sel = cfg.msb_first ? (cfg.count - rgbpk_pkg::COUNT_W'(1) - rgbpk_pkg::COUNT_W'(k))
				: rgbpk_pkg::COUNT_W'(k);
			if (rgbpk_pkg::COUNT_W'(k) < cfg.count) begin
				out_bytes[k] = word[{sel[rgbpk_pkg::SEL_W-1:0], 3'b000} +: 8];
			end else begin
				out_bytes[k] = 8'h00;
			end
		end
	end

endmodule

// ----- rtl/core/rgb888_to_native_pixel_packer_core.sv -----
`timescale 1ns / 1ps

// RGB888 to native pixel packer.
//
// Input stream (s_axis_*): one beat per source pixel, red in tdata[7:0],
// green in [15:8], blue in [23:16].
// Output stream (m_axis_*): one beat per pixel, the bytes in memory order
// in tdata[7:0] .. [31:24] and the valid byte count in [34:32]. Slots at or
// beyond the count read zero.
// Configuration: cfg_wr_en / cfg_index / cfg_wdata write the red, green and
// blue masks, bytes per pixel and byte order. Masks are decoded into
// position and run length as they are written, so change them only while
// no pixel is in flight.
// An input beat passes through the input register, then through the packing
// logic into the output register. Throughput is one pixel per clock while
// the receiver takes beats; the input and output registers each hold a
// beat, so the input side keeps taking a pixel while a finished one waits.
// When the receiver stalls, the output beat holds and the input register
// fills, after which s_axis_tready drops until the output is taken.
// Reset (arst_n low) empties both registers and loads the default format:
// 32-bit XRGB, low byte first.
module rgb888_to_native_pixel_packer_core (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// red_level, green_level, blue_level
	input  logic [rgbpk_pkg::IN_DATA_W-1:0]  s_axis_tdata,

	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_byte0, out_byte1, out_byte2, out_byte3, byte_count, zero fill
	output logic [rgbpk_pkg::OUT_DATA_W-1:0] m_axis_tdata,

	input  logic                             cfg_wr_en,
	input  logic [rgbpk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbpk_pkg::MASK_W-1:0]     cfg_wdata
);

	rgbpk_pkg::pix_cfg_t cfg;

	logic                            valid_s1;
	logic [rgbpk_pkg::LEVEL_W-1:0]   red_s1;
	logic [rgbpk_pkg::LEVEL_W-1:0]   green_s1;
	logic [rgbpk_pkg::LEVEL_W-1:0]   blue_s1;

	logic                            valid_s2;
	logic [rgbpk_pkg::OUT_DATA_W-1:0] data_s2;

	logic [7:0]                      pack_bytes [rgbpk_pkg::OUT_SLOTS];
	logic                            adv_s2;
	logic                            adv_s1;

	rgbpk_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rgbpk_pixel_pack u_pack (
		.red_level   (red_s1),
		.green_level (green_s1),
		.blue_level  (blue_s1),
		.cfg         (cfg),
		.out_bytes   (pack_bytes)
	);

	// Output register loads when empty or when its beat is being taken.
	assign adv_s2 = !valid_s2 || m_axis_tready;
	// Input register takes a beat when empty or when it moves on this cycle.
	assign adv_s1 = !valid_s1 || adv_s2;

	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload: hold while stalled, no reset needed.
	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			red_s1   <= s_axis_tdata[7:0];
			green_s1 <= s_axis_tdata[15:8];
			blue_s1  <= s_axis_tdata[23:16];
		end
		if (adv_s2 && valid_s1) begin
			data_s2 <= {5'b00000, cfg.count, pack_bytes[3], pack_bytes[2],
				pack_bytes[1], pack_bytes[0]};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

endmodule

// ----- rtl/core/rgbpk_checker.sv -----
`timescale 1ns / 1ps

module rgbpk_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [rgbpk_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// A stalled output beat holds its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// A new output beat follows an input beat that passed through the input and output registers.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("output beat without a matching input beat");

	// The byte count stays within 1..4.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[34:32] != 3'd0) && (m_axis_tdata[34:32] <= 3'd4))
		else $error("byte count out of range");

	// Slots past a byte count of one read zero.
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[34:32] == 3'd1) |-> (m_axis_tdata[31:8] == 24'd0))
		else $error("unused pixel bytes not zero");

endmodule

bind rgb888_to_native_pixel_packer_core rgbpk_checker u_rgbpk_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- test/rgb888_to_native_pixel_packer_core_tb.sv -----
`timescale 1ns / 1ps

module rgb888_to_native_pixel_packer_core_tb;

	import rgbpk_pkg::*;

	localparam int LONG_STALL   = 300;
	localparam int MAX_REPORTS  = 10;
	localparam int SETTLE       = 4;

	// Expected pixel: bytes in memory order plus the valid byte count.
	typedef struct packed {
		logic [COUNT_W-1:0]      count;
		logic [OUT_SLOTS-1:0][7:0] bytes;
	} packed_pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [MASK_W-1:0]     cfg_wdata;

	// Shadow copy of the format registers, as last written.
	logic [MASK_W-1:0]     fmt_red_mask;
	logic [MASK_W-1:0]     fmt_green_mask;
	logic [MASK_W-1:0]     fmt_blue_mask;
	logic [COUNT_W-1:0]    fmt_bpp;
	logic                  fmt_msb_first;

	packed_pixel_t         pending_pixels[$];
	int                    mismatches = 0;
	int                    src_idle_pct = 33;
	int                    sink_idle_pct = 53;
	int                    stall_requests = 0;
	int                    stall_served = 0;
	int                    stall_left = 0;

	rgb888_to_native_pixel_packer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Run limit: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Pixel prediction
	// ------------------------------------------------------------------

	// Place one 8-bit level into the field that a mask describes. Only the
	// lowest run of set bits counts, and a run longer than 16 bits is cut
	// to 16 at its lowest bit. A zero mask contributes nothing.
	function automatic logic [63:0] place_level(logic [MASK_W-1:0] mask, logic [7:0] level);
		int          lsb;
		int          run;
		logic [15:0] wide;
		if (mask == '0) begin
			return '0;
		end
		lsb = 0;
		while (!mask[lsb]) lsb++;
		run = 0;
		while (lsb + run < MASK_W && mask[lsb + run]) run++;
		if (run > WIDE_W) begin
			run = WIDE_W;
		end
		// Widen by byte replication, then keep the top run bits.
		wide = {level, level} >> (WIDE_W - run);
		return 64'(wide) << lsb;
	endfunction

	function automatic packed_pixel_t pack_pixel(logic [7:0] red, logic [7:0] green,
			logic [7:0] blue);
		packed_pixel_t pix;
		logic [63:0]   word;
		int            count;
		int            sel;
		count = fmt_bpp;
		if (count < 1) begin
			count = 1;
		end else if (count > BYTE_LIMIT) begin
			count = BYTE_LIMIT;
		end
		word = place_level(fmt_red_mask, red) | place_level(fmt_green_mask, green)
			| place_level(fmt_blue_mask, blue);
		pix = '0;
		pix.count = COUNT_W'(count);
		// Bits above the emitted bytes drop out; unused slots stay zero.
		for (int k = 0; k < count; k++) begin
			sel = fmt_msb_first ? (count - 1 - k) : k;
			pix.bytes[k] = word[8*sel +: 8];
		end
		return pix;
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random ready, plus a long hold-off on request
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (stall_served != stall_requests) begin
			stall_served  <= stall_requests;
			stall_left    <= LONG_STALL - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Output beat checking
	// ------------------------------------------------------------------

	task automatic flag_field(string name, longint unsigned want, longint unsigned got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
		end
	endtask

	// Compare each output beat with the oldest pending pixel.
	always @(posedge clk) begin : check_beats
		packed_pixel_t want;
		packed_pixel_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.bytes = m_axis_tdata[8*OUT_SLOTS-1:0];
			got.count = m_axis_tdata[8*OUT_SLOTS +: COUNT_W];
			if (pending_pixels.size() == 0) begin
				flag_field("unexpected beat", 0, m_axis_tdata);
			end else begin
				want = pending_pixels.pop_front();
				for (int k = 0; k < OUT_SLOTS; k++) begin
					if (got.bytes[k] !== want.bytes[k]) begin
						flag_field($sformatf("out_byte%0d", k), want.bytes[k], got.bytes[k]);
					end
				end
				if (got.count !== want.count) begin
					flag_field("byte_count", want.count, got.count);
				end
				if (m_axis_tdata[OUT_DATA_W-1:8*OUT_SLOTS+COUNT_W] !== '0) begin
					flag_field("zero fill", 0, m_axis_tdata[OUT_DATA_W-1:8*OUT_SLOTS+COUNT_W]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one pixel and hold it until taken. tvalid stays high after the
	// beat so back-to-back pixels need no extra edge; drop it only to idle.
	task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= IN_DATA_W'($urandom);
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {blue, green, red};
		do @(posedge clk); while (!s_axis_tready);
		pending_pixels.push_back(pack_pixel(red, green, blue));
	endtask

	task automatic send_random_pixel();
		send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Stop offering, let every pending pixel drain, then let the pipe settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write one register; the enable stays high so writes can follow back
	// to back. Call end_writes to lower it.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (cfg_reg_t'(idx))
			CFG_RED_MASK:        fmt_red_mask   = value;
			CFG_GREEN_MASK:      fmt_green_mask = value;
			CFG_BLUE_MASK:       fmt_blue_mask  = value;
			CFG_BYTES_PER_PIXEL: fmt_bpp        = value[COUNT_W-1:0];
			CFG_MSB_FIRST:       fmt_msb_first  = value[0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_format(logic [MASK_W-1:0] red, logic [MASK_W-1:0] green,
			logic [MASK_W-1:0] blue, logic [MASK_W-1:0] bpp, logic [MASK_W-1:0] msb);
		write_reg(CFG_RED_MASK, red);
		write_reg(CFG_GREEN_MASK, green);
		write_reg(CFG_BLUE_MASK, blue);
		write_reg(CFG_BYTES_PER_PIXEL, bpp);
		write_reg(CFG_MSB_FIRST, msb);
		end_writes();
	endtask

	// Mix of plausible fields, arbitrary words with gaps, empty and full masks.
	function automatic logic [MASK_W-1:0] random_mask();
		int run;
		int lsb;
		case ($urandom_range(5))
			0: return MASK_W'($urandom);
			1: return '0;
			2: return '1;
			3: begin
				run = $urandom_range(1, MASK_W);
				lsb = $urandom_range(0, MASK_W - run);
				return MASK_W'(((64'd1 << run) - 1) << lsb);
			end
			default: begin
				run = $urandom_range(4, 8);
				lsb = $urandom_range(0, MASK_W - run);
				return MASK_W'(((64'd1 << run) - 1) << lsb);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset format: 32-bit XRGB, low byte first. Hit the level extremes.
	task automatic test_default_format();
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hff, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hff);
		send_pixel(8'h80, 8'h01, 8'h7f);
		drain();
	endtask

	// Corner formats, two pixels each.
	task automatic test_special_formats();
		// RGB565, both byte orders
		set_format(32'h0000_f800, 32'h0000_07e0, 32'h0000_001f, 2, 0);
		send_pixel(8'hff, 8'h00, 8'h80);
		send_pixel(8'h12, 8'hab, 8'hcd);
		drain();
		set_format(32'h0000_f800, 32'h0000_07e0, 32'h0000_001f, 2, 1);
		send_pixel(8'h00, 8'hff, 8'h01);
		send_pixel(8'ha5, 8'h5a, 8'hc3);
		drain();
		// green mask empty: green drops out entirely
		set_format(32'h00ff_0000, 32'h0000_0000, 32'h0000_00ff, 3, 1);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h3c, 8'hff, 8'hc3);
		drain();
		// masks with gaps: only the lowest run counts
		set_format(32'h0f0f_0000, 32'h0000_a0f0, 32'h8000_000f, 4, 0);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h9e, 8'h61, 8'h2d);
		drain();
		// runs over 16 bits clamp to 16; overlapping fields OR together
		set_format(32'hffff_ffff, 32'h00ff_ff00, 32'hffff_0000, 4, 1);
		send_pixel(8'h81, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h42, 8'hf0);
		drain();
		// raw byte count zero acts as one; upper bytes of the word drop
		set_format(32'h00ff_0000, 32'h0000_ff00, 32'h0000_00ff, 0, 0);
		send_pixel(8'hff, 8'hff, 8'h5a);
		send_pixel(8'h11, 8'h22, 8'h33);
		drain();
		// byte count above the limit; fields at the top of the word
		set_format(32'h8000_0000, 32'h7000_0000, 32'h0fff_ff00, 7, 1);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h7f, 8'ha0, 8'h0f);
		drain();
	endtask

	// Random formats under one idle profile, 30 pixels each.
	task automatic test_random_formats(int src_pct, int sink_pct);
		src_idle_pct = src_pct;
		sink_idle_pct <= sink_pct;
		for (int f = 0; f < 5; f++) begin
			// Upper data bits ride along on the narrow registers too.
			write_reg(CFG_RED_MASK, random_mask());
			write_reg(CFG_GREEN_MASK, random_mask());
			write_reg(CFG_BLUE_MASK, random_mask());
			write_reg(CFG_BYTES_PER_PIXEL, MASK_W'($urandom));
			write_reg(CFG_MSB_FIRST, MASK_W'($urandom));
			// Unused indexes must be ignored.
			if ($urandom_range(1) == 1) begin
				write_reg(CFG_IDX_W'(CFG_MSB_FIRST) + CFG_IDX_W'($urandom_range(1, 3)),
					MASK_W'($urandom));
			end
			end_writes();
			repeat (30) send_random_pixel();
			drain();
		end
	endtask

	// Hold the receiver off while the sender keeps pushing: the input
	// and output registers fill and tready must drop without losing a beat.
	task automatic test_backpressure();
		src_idle_pct = 0;
		sink_idle_pct <= 0;
		set_format(32'h0000_f800, 32'h0000_07e0, 32'h0000_001f, 2, 1);
		stall_requests <= stall_requests + 1;
		repeat (40) send_random_pixel();
		drain();
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = CFG_RED_MASK;
		cfg_wdata      = '0;
		fmt_red_mask   = 32'h00ff_0000;
		fmt_green_mask = 32'h0000_ff00;
		fmt_blue_mask  = 32'h0000_00ff;
		fmt_bpp        = 3'd4;
		fmt_msb_first  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_format();
		test_special_formats();
		test_random_formats(33, 53);
		test_random_formats(53, 33);
		test_random_formats(0, 0);
		test_backpressure();

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
